@@ src/stop_wait_arq_sender_core_assert.svh @@
// assertion macros for the stop-and-wait sender core
// used by stop_wait_arq_sender_core.sv; needs clk and arst_n in scope
`ifndef STOP_WAIT_ARQ_SENDER_CORE_ASSERT_SVH
`define STOP_WAIT_ARQ_SENDER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle property, checked out of reset
`define SWARQ_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition in one cycle implies consequence in the next
`define SWARQ_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SWARQ_ASSERT(name, prop, msg)
`define SWARQ_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

@@ src/swarq_pkg.sv @@
// shared types and codes for the stop-and-wait sender core
// no dependencies
package swarq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int WAIT_W      = 7;
	localparam logic [WAIT_W-1:0] QUEUE_DEPTH_W = WAIT_W'(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		EV_START   = 2'd0,
		EV_ACK     = 2'd1,
		EV_NAK     = 2'd2,
		EV_TIMEOUT = 2'd3
	} swarq_kind_t;

	typedef enum logic [1:0] {
		ACT_ENQ   = 2'd0,
		ACT_PKT   = 2'd1,
		ACT_EOT   = 2'd2,
		ACT_ABORT = 2'd3
	} swarq_action_t;

	typedef enum logic [2:0] {
		REG_SYN        = 3'd0,
		REG_ENQ        = 3'd1,
		REG_EOT        = 3'd2,
		REG_SOT_FIRST  = 3'd3,
		REG_SOT_SECOND = 3'd4,
		REG_MAX_PKTS   = 3'd5,
		REG_MAX_FAILS  = 3'd6
	} swarq_reg_t;

	localparam logic [7:0] SYN_RST        = 8'd22;
	localparam logic [7:0] ENQ_RST        = 8'd5;
	localparam logic [7:0] EOT_RST        = 8'd4;
	localparam logic [7:0] SOT_FIRST_RST  = 8'd1;
	localparam logic [7:0] SOT_SECOND_RST = 8'd2;
	localparam logic [3:0] MAX_PKTS_RST   = 4'd5;
	localparam logic [3:0] MAX_FAILS_RST  = 4'd5;

	typedef struct packed {
		logic [7:0] syn_code;
		logic [7:0] enq_code;
		logic [7:0] eot_code;
		logic [7:0] sot_first_code;
		logic [7:0] sot_second_code;
		logic [3:0] max_packets;
		logic [3:0] max_failures;
	} swarq_cfg_t;

endpackage

@@ src/swarq_cfg.sv @@
// apb register file for the stop-and-wait sender core
// depends on swarq_pkg
module swarq_cfg import swarq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output swarq_cfg_t  cfg
);

	swarq_cfg_t cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.syn_code        <= SYN_RST;
			cfg_q.enq_code        <= ENQ_RST;
			cfg_q.eot_code        <= EOT_RST;
			cfg_q.sot_first_code  <= SOT_FIRST_RST;
			cfg_q.sot_second_code <= SOT_SECOND_RST;
			cfg_q.max_packets     <= MAX_PKTS_RST;
			cfg_q.max_failures    <= MAX_FAILS_RST;
		end else if (wr_en) begin
			case (swarq_reg_t'(reg_idx))
				REG_SYN:        cfg_q.syn_code        <= pwdata[7:0];
				REG_ENQ:        cfg_q.enq_code        <= pwdata[7:0];
				REG_EOT:        cfg_q.eot_code        <= pwdata[7:0];
				REG_SOT_FIRST:  cfg_q.sot_first_code  <= pwdata[7:0];
				REG_SOT_SECOND: cfg_q.sot_second_code <= pwdata[7:0];
				REG_MAX_PKTS:   cfg_q.max_packets     <= pwdata[3:0];
				REG_MAX_FAILS:  cfg_q.max_failures    <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (swarq_reg_t'(reg_idx))
			REG_SYN:        prdata = {24'd0, cfg_q.syn_code};
			REG_ENQ:        prdata = {24'd0, cfg_q.enq_code};
			REG_EOT:        prdata = {24'd0, cfg_q.eot_code};
			REG_SOT_FIRST:  prdata = {24'd0, cfg_q.sot_first_code};
			REG_SOT_SECOND: prdata = {24'd0, cfg_q.sot_second_code};
			REG_MAX_PKTS:   prdata = {28'd0, cfg_q.max_packets};
			REG_MAX_FAILS:  prdata = {28'd0, cfg_q.max_failures};
			default:        prdata = 32'd0;
		endcase
	end

endmodule

@@ src/stop_wait_arq_sender_core.sv @@
// channel   dir  handshake            payload
// event     in   evt_valid/evt_ready  kind, packets_waiting
// result    out  res_valid/res_ready  action, prefix_byte, control_byte, drop_head, total_sent
// config    in   apb psel/penable     paddr, pwdata, prdata
//
// one event per cycle sustained while the result sink keeps up; a result passes the input
// register, then the result register; the session state feeds back through its register
// events that cause no result are dropped after the input register
// reset clears the session state and the ack count and loads register defaults
// a stalled result holds the result register; evt_ready drops only when both stages are full
//
// top level of the stop-and-wait sender; depends on swarq_pkg, swarq_cfg
// and stop_wait_arq_sender_core_assert.svh
`include "stop_wait_arq_sender_core_assert.svh"

module stop_wait_arq_sender_core import swarq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        evt_valid,
	output logic        evt_ready,
	input  logic [1:0]  kind,
	input  logic [6:0]  packets_waiting,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [1:0]  action,
	output logic [7:0]  prefix_byte,
	output logic [7:0]  control_byte,
	output logic        drop_head,
	output logic [31:0] total_sent
);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_ENQ  = 2'd1,
		PH_SEND = 2'd2
	} phase_t;

	swarq_cfg_t cfg;

	// input stage
	logic              valid_s1;
	swarq_kind_t       kind_s1;
	logic [WAIT_W-1:0] waiting_s1;

	// session state
	phase_t      phase_q;
	logic        sot_q;
	logic [3:0]  sess_q;
	logic [3:0]  fail_q;
	logic [31:0] acked_q;

	// result register
	logic          res_valid_q;
	swarq_action_t action_q;
	logic [7:0]    prefix_q;
	logic [7:0]    control_q;
	logic          drop_q;
	logic [31:0]   total_q;

	// decision
	logic              advance;
	logic [WAIT_W-1:0] wait_c;
	logic              wait_zero;
	logic              wait_one;
	logic [7:0]        sot_cur;
	logic [7:0]        sot_next;
	logic              emit;
	swarq_action_t     act_d;
	logic [7:0]        prefix_d;
	logic [7:0]        control_d;
	logic              drop_d;
	phase_t            phase_d;
	logic              sot_d;
	logic [3:0]        sess_d;
	logic [3:0]        fail_d;
	logic [31:0]       acked_d;

	swarq_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready    = 1'b1;
	assign advance   = valid_s1 && (!res_valid_q || res_ready);
	assign evt_ready = !valid_s1 || advance;

	assign wait_c    = (waiting_s1 > QUEUE_DEPTH_W) ? QUEUE_DEPTH_W : waiting_s1;
	assign wait_zero = (wait_c == '0);
	assign wait_one  = (wait_c == WAIT_W'(1));
	assign sot_cur   = sot_q ? cfg.sot_second_code : cfg.sot_first_code;
	assign sot_next  = sot_q ? cfg.sot_first_code : cfg.sot_second_code;

	always_comb begin
		emit      = 1'b0;
		act_d     = ACT_ENQ;
		prefix_d  = 8'd0;
		control_d = 8'd0;
		drop_d    = 1'b0;
		phase_d   = phase_q;
		sot_d     = sot_q;
		sess_d    = sess_q;
		fail_d    = fail_q;
		acked_d   = acked_q;
		case (phase_q)
			PH_ENQ: begin
				if (kind_s1 != EV_START) begin
					emit = 1'b1;
					if (kind_s1 == EV_ACK) begin
						if (wait_zero || sess_q >= cfg.max_packets) begin
							act_d     = ACT_EOT;
							prefix_d  = cfg.syn_code;
							control_d = cfg.eot_code;
							phase_d   = PH_IDLE;
						end else begin
							act_d     = ACT_PKT;
							control_d = sot_cur;
							phase_d   = PH_SEND;
						end
					end else begin
						// failed enquiry, no eot
						act_d   = ACT_ABORT;
						phase_d = PH_IDLE;
					end
				end
			end
			PH_SEND: begin
				if (kind_s1 != EV_START) begin
					emit = 1'b1;
					if (kind_s1 == EV_ACK) begin
						drop_d  = !wait_zero;
						sot_d   = !sot_q;
						sess_d  = sess_q + 4'd1;
						acked_d = acked_q + 32'd1;
						fail_d  = 4'd0;
						// the head goes away, so one waiting packet leaves none
						if (wait_zero || wait_one || sess_d >= cfg.max_packets) begin
							act_d     = ACT_EOT;
							prefix_d  = cfg.syn_code;
							control_d = cfg.eot_code;
							phase_d   = PH_IDLE;
						end else begin
							act_d     = ACT_PKT;
							control_d = sot_next;
						end
					end else begin
						fail_d = fail_q + 4'd1;
						if (fail_d >= cfg.max_failures) begin
							act_d   = ACT_ABORT;
							phase_d = PH_IDLE;
						end else if (wait_zero) begin
							act_d     = ACT_EOT;
							prefix_d  = cfg.syn_code;
							control_d = cfg.eot_code;
							phase_d   = PH_IDLE;
						end else begin
							act_d     = ACT_PKT;
							control_d = sot_cur;
						end
					end
				end
			end
			default: begin
				// idle, and the unused phase code behaves as idle
				phase_d = PH_IDLE;
				if (kind_s1 == EV_START && !wait_zero) begin
					emit      = 1'b1;
					act_d     = ACT_ENQ;
					prefix_d  = cfg.syn_code;
					control_d = cfg.enq_code;
					sot_d     = 1'b0;
					sess_d    = 4'd0;
					fail_d    = 4'd0;
					phase_d   = PH_ENQ;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt_ready) begin
			valid_s1 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_valid && evt_ready) begin
			kind_s1    <= swarq_kind_t'(kind);
			waiting_s1 <= packets_waiting;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			sot_q   <= 1'b0;
			sess_q  <= 4'd0;
			fail_q  <= 4'd0;
			acked_q <= 32'd0;
		end else if (advance) begin
			phase_q <= phase_d;
			sot_q   <= sot_d;
			sess_q  <= sess_d;
			fail_q  <= fail_d;
			acked_q <= acked_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= emit;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			action_q  <= act_d;
			prefix_q  <= prefix_d;
			control_q <= control_d;
			drop_q    <= drop_d;
			total_q   <= acked_d;
		end
	end

	assign res_valid    = res_valid_q;
	assign action       = action_q;
	assign prefix_byte  = prefix_q;
	assign control_byte = control_q;
	assign drop_head    = drop_q;
	assign total_sent   = total_q;

	`SWARQ_ASSERT(a_abort_silent, action_q == ACT_ABORT |-> {prefix_q, control_q} == '0, "abort bytes")
	`SWARQ_ASSERT(a_drop_kind, drop_q |-> action_q == ACT_PKT || action_q == ACT_EOT, "drop on enq")
	`SWARQ_ASSERT(a_stall_blocks, valid_s1 && res_valid_q && !res_ready |-> !evt_ready, "ready in stall")
	`SWARQ_ASSERT_NEXT(a_enq_phase, advance && emit && act_d == ACT_ENQ, phase_q == PH_ENQ, "enq phase")
	`SWARQ_ASSERT_NEXT(a_ack_fail, advance && phase_q == PH_SEND && kind_s1 == EV_ACK, fail_q == '0, "fail run")

endmodule

@@ test/tb_stop_wait_arq_sender_core.sv @@
`timescale 1ns / 1ps
// self-checking testbench for stop_wait_arq_sender_core: a directed event table, then
// random link sessions under several register settings and handshake stall patterns
// depends on swarq_pkg and the core rtl
module tb_stop_wait_arq_sender_core;
	import swarq_pkg::*;

	localparam int REG_COUNT     = 7;
	localparam int DIRECTED_ROWS = 25;
	localparam int PHASES        = 9;
	localparam int PHASE_EVENTS  = 155;
	localparam int DRAIN_GAP     = 8;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int MAX_REPORTS   = 10;

	typedef enum logic [1:0] {
		LS_IDLE = 2'd0,
		LS_ENQ  = 2'd1,
		LS_SEND = 2'd2
	} link_state_t;

	typedef struct packed {
		swarq_action_t action;
		logic [7:0]    prefix;
		logic [7:0]    control;
		logic          drop;
		logic [31:0]   total;
	} frame_t;

	typedef struct packed {
		swarq_kind_t kind;
		logic [6:0]  waiting;
		logic        typed;
		logic        has_res;
		frame_t      want;
	} link_event_t;

	// rows marked typed carry their own expected frame, the others use the predictor
	localparam link_event_t DIRECTED [DIRECTED_ROWS] = '{
		'{EV_ACK,     7'd3,   1'b1, 1'b0, '0},
		'{EV_START,   7'd0,   1'b1, 1'b0, '0},
		'{EV_START,   7'd3,   1'b1, 1'b1, '{ACT_ENQ, 8'd22, 8'd5, 1'b0, 32'd0}},
		'{EV_START,   7'd3,   1'b1, 1'b0, '0},
		'{EV_ACK,     7'd3,   1'b1, 1'b1, '{ACT_PKT, 8'd0, 8'd1, 1'b0, 32'd0}},
		'{EV_ACK,     7'd3,   1'b0, 1'b0, '0},
		'{EV_NAK,     7'd2,   1'b0, 1'b0, '0},
		'{EV_TIMEOUT, 7'd2,   1'b0, 1'b0, '0},
		'{EV_ACK,     7'd0,   1'b0, 1'b0, '0},
		'{EV_START,   7'd64,  1'b0, 1'b0, '0},
		'{EV_NAK,     7'd64,  1'b1, 1'b1, '{ACT_ABORT, 8'd0, 8'd0, 1'b0, 32'd2}},
		'{EV_START,   7'd127, 1'b0, 1'b0, '0},
		'{EV_TIMEOUT, 7'd5,   1'b1, 1'b1, '{ACT_ABORT, 8'd0, 8'd0, 1'b0, 32'd2}},
		'{EV_START,   7'd1,   1'b0, 1'b0, '0},
		'{EV_ACK,     7'd0,   1'b0, 1'b0, '0},
		'{EV_START,   7'd10,  1'b0, 1'b0, '0},
		'{EV_ACK,     7'd10,  1'b0, 1'b0, '0},
		'{EV_NAK,     7'd10,  1'b0, 1'b0, '0},
		'{EV_TIMEOUT, 7'd10,  1'b0, 1'b0, '0},
		'{EV_NAK,     7'd10,  1'b0, 1'b0, '0},
		'{EV_TIMEOUT, 7'd10,  1'b0, 1'b0, '0},
		'{EV_NAK,     7'd10,  1'b0, 1'b0, '0},
		'{EV_START,   7'd2,   1'b0, 1'b0, '0},
		'{EV_ACK,     7'd2,   1'b0, 1'b0, '0},
		'{EV_NAK,     7'd0,   1'b0, 1'b0, '0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        evt_valid = 1'b0;
	logic        evt_ready;
	logic [1:0]  kind = '0;
	logic [6:0]  packets_waiting = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic [1:0]  action;
	logic [7:0]  prefix_byte;
	logic [7:0]  control_byte;
	logic        drop_head;
	logic [31:0] total_sent;

	stop_wait_arq_sender_core dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the link state and registers
	swarq_cfg_t  link_cfg;
	link_state_t link_state;
	logic        sot_sel;
	logic [3:0]  session_cnt;
	logic [3:0]  fail_cnt;
	logic [31:0] ack_count;

	link_event_t event_backlog[$];
	frame_t      pending_results[$];
	int          src_idle_pct = 0;
	int          sink_stall_pct = 0;
	int          fail_count = 0;
	int          events_accepted = 0;
	int          results_checked = 0;
	int          settings_used = 0;

	function automatic logic [7:0] current_sot();
		return sot_sel ? link_cfg.sot_second_code : link_cfg.sot_first_code;
	endfunction

	function automatic void close_or_send(input logic [6:0] remaining, input logic drop,
			output frame_t f);
		if (remaining == 7'd0 || session_cnt >= link_cfg.max_packets) begin
			link_state = LS_IDLE;
			f = '{ACT_EOT, link_cfg.syn_code, link_cfg.eot_code, drop, ack_count};
		end else begin
			link_state = LS_SEND;
			f = '{ACT_PKT, 8'd0, current_sot(), drop, ack_count};
		end
	endfunction

	// decide one event; returns 1 when it produces a result frame
	function automatic logic arq_decide(input swarq_kind_t k, input logic [6:0] pw,
			output frame_t f);
		logic [6:0] queued;
		logic       drop;
		queued = (pw > QUEUE_DEPTH_W) ? QUEUE_DEPTH_W : pw;
		f = '0;
		if (link_state != LS_ENQ && link_state != LS_SEND) begin
			link_state = LS_IDLE;
			if (k != EV_START || queued == 7'd0)
				return 1'b0;
			sot_sel = 1'b0;
			session_cnt = '0;
			fail_cnt = '0;
			link_state = LS_ENQ;
			f = '{ACT_ENQ, link_cfg.syn_code, link_cfg.enq_code, 1'b0, ack_count};
			return 1'b1;
		end
		if (k == EV_START)
			return 1'b0;
		if (link_state == LS_ENQ) begin
			if (k == EV_ACK) begin
				close_or_send(queued, 1'b0, f);
			end else begin
				link_state = LS_IDLE;
				f = '{ACT_ABORT, 8'd0, 8'd0, 1'b0, ack_count};
			end
			return 1'b1;
		end
		if (k == EV_ACK) begin
			drop = (queued != 7'd0);
			sot_sel = ~sot_sel;
			session_cnt = session_cnt + 4'd1;
			ack_count = ack_count + 32'd1;
			fail_cnt = '0;
			close_or_send(drop ? queued - 7'd1 : 7'd0, drop, f);
			return 1'b1;
		end
		fail_cnt = fail_cnt + 4'd1;
		if (fail_cnt >= link_cfg.max_failures) begin
			link_state = LS_IDLE;
			f = '{ACT_ABORT, 8'd0, 8'd0, 1'b0, ack_count};
		end else if (queued == 7'd0) begin
			link_state = LS_IDLE;
			f = '{ACT_EOT, link_cfg.syn_code, link_cfg.eot_code, 1'b0, ack_count};
		end else begin
			f = '{ACT_PKT, 8'd0, current_sot(), 1'b0, ack_count};
		end
		return 1'b1;
	endfunction

	function automatic string show(input frame_t f);
		return $sformatf("%s prefix=%0d control=%0d drop=%0b total=%0d",
			f.action.name(), f.prefix, f.control, f.drop, f.total);
	endfunction

	function automatic void flag_failure(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("mismatch: %s", msg);
	endfunction

	function automatic logic [31:0] cfg_value(input int idx);
		case (idx)
			REG_SYN:        return {24'd0, link_cfg.syn_code};
			REG_ENQ:        return {24'd0, link_cfg.enq_code};
			REG_EOT:        return {24'd0, link_cfg.eot_code};
			REG_SOT_FIRST:  return {24'd0, link_cfg.sot_first_code};
			REG_SOT_SECOND: return {24'd0, link_cfg.sot_second_code};
			REG_MAX_PKTS:   return {28'd0, link_cfg.max_packets};
			REG_MAX_FAILS:  return {28'd0, link_cfg.max_failures};
			default:        return 32'd0;
		endcase
	endfunction

	// event source: offer the next beat whenever the slot is free, unless the source idles at random
	always @(posedge clk) begin : drive_events
		link_event_t on_wire;
		frame_t      f;
		logic        has;
		if (evt_valid && evt_ready) begin
			events_accepted++;
			has = arq_decide(on_wire.kind, on_wire.waiting, f);
			if (on_wire.typed) begin
				if (on_wire.has_res)
					pending_results.push_back(on_wire.want);
			end else if (has) begin
				pending_results.push_back(f);
			end
		end
		if (!evt_valid || evt_ready) begin
			if (event_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				on_wire = event_backlog.pop_front();
				evt_valid <= 1'b1;
				kind <= on_wire.kind;
				packets_waiting <= on_wire.waiting;
			end else begin
				evt_valid <= 1'b0;
			end
		end
	end

	// result sink: check each beat against the oldest expected frame
	always @(posedge clk) begin : check_results
		frame_t got;
		frame_t want;
		if (res_valid && res_ready) begin
			got = '{swarq_action_t'(action), prefix_byte, control_byte, drop_head, total_sent};
			if (pending_results.size() == 0) begin
				flag_failure($sformatf("unexpected result %s", show(got)));
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (got !== want)
					flag_failure($sformatf("expected %s, got %s", show(want), show(got)));
			end
		end
		res_ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	task automatic apb_access(input logic write, input int idx, input logic [31:0] data,
			output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= 5'(idx * 4);
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic reg_write(input int idx, input logic [31:0] data);
		logic [31:0] unused;
		apb_access(1'b1, idx, data, unused);
		case (idx)
			REG_SYN:        link_cfg.syn_code = data[7:0];
			REG_ENQ:        link_cfg.enq_code = data[7:0];
			REG_EOT:        link_cfg.eot_code = data[7:0];
			REG_SOT_FIRST:  link_cfg.sot_first_code = data[7:0];
			REG_SOT_SECOND: link_cfg.sot_second_code = data[7:0];
			REG_MAX_PKTS:   link_cfg.max_packets = data[3:0];
			REG_MAX_FAILS:  link_cfg.max_failures = data[3:0];
			default:        ;
		endcase
	endtask

	task automatic check_registers();
		logic [31:0] rd;
		for (int i = 0; i < REG_COUNT; i++) begin
			apb_access(1'b0, i, 32'd0, rd);
			if (rd !== cfg_value(i))
				flag_failure($sformatf("register %0d reads %0h, expected %0h",
					i, rd, cfg_value(i)));
		end
	endtask

	// register settings per phase; the extremes sit in phases two to six
	task automatic write_settings(input int p);
		logic [31:0] limit_pkts;
		logic [31:0] limit_fails;
		for (int i = REG_SYN; i <= REG_SOT_SECOND; i++) begin
			if (p == 2)
				reg_write(i, 32'd0);
			else if (p == 3)
				reg_write(i, 32'hFFFF_FFFF);
			else
				reg_write(i, $urandom);
		end
		case (p)
			2:       begin limit_pkts = 32'd0;  limit_fails = 32'd0;  end
			3:       begin limit_pkts = 32'hFFFF_FFFF; limit_fails = 32'hFFFF_FFFF; end
			4:       begin limit_pkts = 32'd1;  limit_fails = 32'd1;  end
			5:       begin limit_pkts = 32'd15; limit_fails = 32'd0;  end
			6:       begin limit_pkts = 32'd0;  limit_fails = 32'd15; end
			default: begin
				limit_pkts = ($urandom & 32'hFFFF_FFF0) | $urandom_range(1, 15);
				limit_fails = ($urandom & 32'hFFFF_FFF0) | $urandom_range(1, 15);
			end
		endcase
		reg_write(REG_MAX_PKTS, limit_pkts);
		reg_write(REG_MAX_FAILS, limit_fails);
		// index past the last register: the write must change nothing
		if (p == 7)
			reg_write(REG_COUNT, $urandom);
		settings_used++;
	endtask

	task automatic push_event(input swarq_kind_t k, input int w);
		link_event_t ev;
		ev = '0;
		ev.kind = k;
		ev.waiting = 7'(w);
		event_backlog.push_back(ev);
	endtask

	function automatic int pick_queue();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(1, 6);
		else if (r < 80)
			return 0;
		else if (r < 90)
			return $urandom_range(7, 64);
		return $urandom_range(65, 127);
	endfunction

	// mostly well-formed sessions with random replies, plus noise and cut-off sessions
	task automatic queue_sessions(input int n);
		int count;
		int q;
		int len;
		int r;
		count = 0;
		while (count < n) begin
			if ($urandom_range(99) < 12) begin
				push_event(swarq_kind_t'($urandom_range(3)), $urandom_range(127));
				count++;
			end else begin
				q = pick_queue();
				push_event(EV_START, q);
				count++;
				len = $urandom_range(2, 3 + 2 * link_cfg.max_packets);
				for (int j = 0; j < len && count < n; j++) begin
					r = $urandom_range(99);
					if (r < 55) begin
						push_event(EV_ACK, q);
						q = (q > 64) ? 63 : ((q > 0) ? q - 1 : 0);
					end else if (r < 85) begin
						push_event($urandom_range(1) ? EV_NAK : EV_TIMEOUT, q);
					end else if (r < 90) begin
						push_event(EV_START, q);
					end else if (r < 95) begin
						push_event(EV_ACK, $urandom_range(127));
					end else begin
						j = len;
					end
					count++;
				end
			end
		end
	endtask

	task automatic drain();
		int waited;
		waited = 0;
		do begin
			@(posedge clk);
			#1;
			waited++;
		end while ((event_backlog.size() != 0 || evt_valid || pending_results.size() != 0)
			&& waited < DRAIN_LIMIT);
		// events with no result may still sit in the pipeline
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	initial begin
		link_cfg = '{SYN_RST, ENQ_RST, EOT_RST, SOT_FIRST_RST, SOT_SECOND_RST,
			MAX_PKTS_RST, MAX_FAILS_RST};
		link_state = LS_IDLE;
		sot_sel = 1'b0;
		session_cnt = '0;
		fail_cnt = '0;
		ack_count = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		for (int p = 0; p < PHASES; p++) begin
			case (p % 4)
				0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1:       begin src_idle_pct = 48; sink_stall_pct = 0;  end
				2:       begin src_idle_pct = 0;  sink_stall_pct = 48; end
				default: begin src_idle_pct = 7;  sink_stall_pct = 7;  end
			endcase
			if (p != 0)
				write_settings(p);
			check_registers();
			if (p == 0) begin
				for (int d = 0; d < DIRECTED_ROWS; d++)
					event_backlog.push_back(DIRECTED[d]);
			end
			queue_sessions(PHASE_EVENTS);
			drain();
		end
		if (pending_results.size() != 0)
			flag_failure($sformatf("%0d expected results never arrived",
				pending_results.size()));
		$display("covered %0d events and %0d checked results over %0d register settings",
			events_accepted, results_checked, settings_used + 1);
		$display("failures: %0d", fail_count);
		if (fail_count == 0) begin
			$display("stop_wait_arq_sender_core regression: pass");
		end else begin
			$display("stop_wait_arq_sender_core regression: fail");
		end
		$finish;
	end

	initial begin
		#4ms;
		$display("timeout waiting for the link to drain");
		$display("stop_wait_arq_sender_core regression: fail");
		$finish;
	end

endmodule
